// ===== rtl/core/lrast_pkg.sv =====
// shared types and constants for the lazy range add/assign/sum tree
package lrast_pkg;

   localparam int DEF_MAX_LEN    = 1024;
   localparam int DEF_NODE_COUNT = 4096;

   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;

   localparam logic [IDX_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;
   localparam logic             CSR_ACTIVE_LENGTH   = 1'b0;

   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_ASSIGN   = 2'd1;
   localparam logic [1:0] REQ_SUM      = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      PH_ENTER,
      PH_LEFT,
      PH_RIGHT,
      PH_DONE
   } phase_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLR,
      OP_LOAD,
      OP_RD_CUR,
      OP_COVER,
      OP_LATCH_PAR,
      OP_RD_LC,
      OP_WR_LC,
      OP_RD_RC,
      OP_WR_RC,
      OP_WR_PAR,
      OP_PH_LEFT,
      OP_PH_RIGHT,
      OP_LIFT_L,
      OP_LIFT_R,
      OP_LIFT_WR,
      OP_POP,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] add;
      logic [DATA_W-1:0] aval;
      logic              pend;
   } node_word_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic      clr_last;
      logic      bad;
      logic      is_query;
      logic      n_ok;
      logic      covered;
      phase_type phase;
      logic      has_tag;
      logic      sp_empty;
   } dp_stat_type;

endpackage

// ===== rtl/core/lrast_ctrl.sv =====
// sequencer that walks the tree one node access at a time
module lrast_ctrl import lrast_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_VISIT,
      ST_COVER_WR,
      ST_POP,
      ST_SP_CHK,
      ST_SP_LRD,
      ST_SP_LWR,
      ST_SP_RRD,
      ST_SP_RWR,
      ST_SP_PWR,
      ST_LIFT_A,
      ST_LIFT_B,
      ST_LIFT_C,
      ST_LIFT_D,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLR;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = stat.bad ? ST_FINISH : ST_VISIT;
         ST_VISIT: begin
            case (stat.phase)
               PH_ENTER: begin
                  if (!stat.n_ok) begin
                     state_in = ST_POP;
                  end else begin
                     cmd.op   = OP_RD_CUR;
                     state_in = stat.covered ? ST_COVER_WR : ST_SP_CHK;
                  end
               end
               PH_LEFT:  cmd.op = OP_PH_LEFT;
               PH_RIGHT: cmd.op = OP_PH_RIGHT;
               default:  state_in = stat.is_query ? ST_POP : ST_LIFT_A;
            endcase
         end
         ST_COVER_WR: begin
            cmd.op   = OP_COVER;
            state_in = ST_POP;
         end
         ST_POP: begin
            if (stat.sp_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_POP;
               state_in = ST_VISIT;
            end
         end
         ST_SP_CHK: begin
            cmd.op   = OP_LATCH_PAR;
            state_in = stat.has_tag ? ST_SP_LRD : ST_VISIT;
         end
         ST_SP_LRD: begin
            cmd.op   = OP_RD_LC;
            state_in = ST_SP_LWR;
         end
         ST_SP_LWR: begin
            cmd.op   = OP_WR_LC;
            state_in = ST_SP_RRD;
         end
         ST_SP_RRD: begin
            cmd.op   = OP_RD_RC;
            state_in = ST_SP_RWR;
         end
         ST_SP_RWR: begin
            cmd.op   = OP_WR_RC;
            state_in = ST_SP_PWR;
         end
         ST_SP_PWR: begin
            cmd.op   = OP_WR_PAR;
            state_in = ST_VISIT;
         end
         ST_LIFT_A: begin
            cmd.op   = OP_RD_LC;
            state_in = ST_LIFT_B;
         end
         ST_LIFT_B: begin
            cmd.op   = OP_LIFT_L;
            state_in = ST_LIFT_C;
         end
         ST_LIFT_C: begin
            cmd.op   = OP_LIFT_R;
            state_in = ST_LIFT_D;
         end
         ST_LIFT_D: begin
            cmd.op   = OP_LIFT_WR;
            state_in = ST_POP;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/lrast_dp.sv =====
// node memory, traversal stack, multiplier and accumulator of the tree
module lrast_dp import lrast_pkg::*; #(
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int NODE_COUNT = DEF_NODE_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic [1:0]        req_type,
   input  logic [IDX_W-1:0]  req_range_low,
   input  logic [IDX_W-1:0]  req_range_high,
   input  logic [DATA_W-1:0] req_operand_value,
   input  logic [IDX_W-1:0]  active_length,
   output logic [DATA_W-1:0] rsp_range_sum,
   output logic              rsp_status
);

   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int AW  = $clog2(NODE_COUNT);
   localparam int NW  = AW + 1;
   localparam int STK = $clog2(MAX_LEN) + 2;
   localparam int SPW = $clog2(STK + 1);
   localparam int SIW = $clog2(STK);

   typedef struct packed {
      logic [NW-1:0] n;
      logic [LW-1:0] l;
      logic [LW-1:0] r;
      phase_type     ph;
   } frame_type;

   node_word_type mem [NODE_COUNT];
   node_word_type rd_ff;
   node_word_type par_ff, par_in;
   frame_type     stack_ff [STK];
   frame_type     cur_ff, cur_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [1:0]        kind_ff, kind_in;
   logic [LW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              bad_ff, bad_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   logic [DATA_W-1:0] mul_ff, mul_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              push;
   frame_type         push_frame;
   logic              mem_we;
   logic [AW-1:0]     mem_wa, mem_ra;
   node_word_type     mem_wd;
   logic [DATA_W-1:0] mul_a;
   logic [LW-1:0]     mul_b;

   logic [NW-1:0]     lc_n, rc_n;
   logic              n_ok, lc_ok, rc_ok;
   logic [LW:0]       lr_sum;
   logic [LW-1:0]     mid, cnt_cover, lcnt, rcnt, len_eff;
   logic [DATA_W-1:0] par_op;
   node_word_type     child_new;
   logic              is_query;

   assign lc_n      = {cur_ff.n[NW-2:0], 1'b0};
   assign rc_n      = {cur_ff.n[NW-2:0], 1'b1};
   assign n_ok      = cur_ff.n < NW'(NODE_COUNT);
   assign lc_ok     = lc_n < NW'(NODE_COUNT);
   assign rc_ok     = rc_n < NW'(NODE_COUNT);
   assign lr_sum    = {1'b0, cur_ff.l} + {1'b0, cur_ff.r};
   assign mid       = lr_sum[LW:1];
   assign cnt_cover = cur_ff.r - cur_ff.l + LW'(1);
   assign lcnt      = mid - cur_ff.l + LW'(1);
   assign rcnt      = cur_ff.r - mid;
   assign is_query  = (kind_ff == REQ_SUM);

   // zero and oversize lengths are clamped
   always_comb begin
      if (active_length == '0) begin
         len_eff = LW'(1);
      end else if (32'(active_length) > 32'(MAX_LEN)) begin
         len_eff = LW'(MAX_LEN);
      end else begin
         len_eff = LW'(active_length);
      end
   end

   // a pending assign folds into the add: (aval + add) * cnt
   assign par_op = par_ff.pend ? (par_ff.aval + par_ff.add) : par_ff.add;

   always_comb begin
      if (par_ff.pend) begin
         child_new = '{sum: mul_ff, add: par_ff.add, aval: par_ff.aval, pend: 1'b1};
      end else begin
         child_new = '{sum: rd_ff.sum + mul_ff, add: rd_ff.add + par_ff.add,
                       aval: rd_ff.aval, pend: rd_ff.pend};
      end
   end

   assign mul_in = mul_a * 32'(mul_b);

   always_comb begin
      par_in        = par_ff;
      cur_in        = cur_ff;
      sp_in         = sp_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      val_in        = val_ff;
      bad_in        = bad_ff;
      acc_in        = acc_ff;
      tmp_in        = tmp_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      push          = 1'b0;
      push_frame    = cur_ff;
      mem_we        = 1'b0;
      mem_wa        = cur_ff.n[AW-1:0];
      mem_wd        = '0;
      mem_ra        = cur_ff.n[AW-1:0];
      mul_a         = val_ff;
      mul_b         = cnt_cover;
      case (cmd.op)
         OP_CLR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
         end
         OP_LOAD: begin
            kind_in = req_type;
            lo_in   = LW'(req_range_low);
            hi_in   = LW'(req_range_high);
            val_in  = req_operand_value;
            bad_in  = (req_type == REQ_RESERVED) || (req_range_low == '0) ||
                      (req_range_low > req_range_high) ||
                      (32'(req_range_high) > 32'(len_eff));
            acc_in  = '0;
            sp_in   = '0;
            cur_in  = '{n: NW'(1), l: LW'(1), r: len_eff, ph: PH_ENTER};
         end
         OP_RD_CUR: ;
         OP_COVER: begin
            if (is_query) begin
               acc_in = acc_ff + rd_ff.sum;
            end else begin
               mem_we = 1'b1;
               if (kind_ff == REQ_ASSIGN) begin
                  mem_wd = '{sum: mul_ff, add: '0, aval: val_ff, pend: 1'b1};
               end else begin
                  mem_wd = '{sum: rd_ff.sum + mul_ff, add: rd_ff.add + val_ff,
                             aval: rd_ff.aval, pend: rd_ff.pend};
               end
            end
         end
         OP_LATCH_PAR: begin
            par_in    = rd_ff;
            cur_in.ph = PH_LEFT;
         end
         OP_RD_LC: begin
            mem_ra = lc_n[AW-1:0];
            mul_a  = par_op;
            mul_b  = lcnt;
         end
         OP_WR_LC: begin
            mem_we = lc_ok;
            mem_wa = lc_n[AW-1:0];
            mem_wd = child_new;
         end
         OP_RD_RC: begin
            mem_ra = rc_n[AW-1:0];
            mul_a  = par_op;
            mul_b  = rcnt;
         end
         OP_WR_RC: begin
            mem_we = rc_ok;
            mem_wa = rc_n[AW-1:0];
            mem_wd = child_new;
         end
         OP_WR_PAR: begin
            mem_we = 1'b1;
            mem_wd = '{sum: par_ff.sum, add: '0, aval: par_ff.aval, pend: 1'b0};
         end
         OP_PH_LEFT: begin
            if (lo_ff <= mid) begin
               push          = 1'b1;
               push_frame.ph = PH_RIGHT;
               sp_in         = sp_ff + SPW'(1);
               cur_in        = '{n: lc_n, l: cur_ff.l, r: mid, ph: PH_ENTER};
            end else begin
               cur_in.ph = PH_RIGHT;
            end
         end
         OP_PH_RIGHT: begin
            if (hi_ff > mid) begin
               push          = 1'b1;
               push_frame.ph = PH_DONE;
               sp_in         = sp_ff + SPW'(1);
               cur_in        = '{n: rc_n, l: mid + LW'(1), r: cur_ff.r, ph: PH_ENTER};
            end else begin
               cur_in.ph = PH_DONE;
            end
         end
         OP_LIFT_L: begin
            mem_ra = rc_n[AW-1:0];
            tmp_in = lc_ok ? rd_ff.sum : '0;
         end
         OP_LIFT_R: begin
            tmp_in = tmp_ff + (rc_ok ? rd_ff.sum : '0);
         end
         OP_LIFT_WR: begin
            mem_we = 1'b1;
            mem_wd = '{sum: tmp_ff, add: rd_ff.add, aval: rd_ff.aval, pend: rd_ff.pend};
         end
         OP_POP: begin
            sp_in  = sp_ff - SPW'(1);
            cur_in = stack_ff[SIW'(sp_ff - SPW'(1))];
         end
         OP_RESULT: begin
            rsp_sum_in    = acc_ff;
            rsp_status_in = bad_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (push) stack_ff[sp_ff[SIW-1:0]] <= push_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         clr_ff <= '0;
      end else begin
         sp_ff  <= sp_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      par_ff        <= par_in;
      cur_ff        <= cur_in;
      kind_ff       <= kind_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      val_ff        <= val_in;
      bad_ff        <= bad_in;
      acc_ff        <= acc_in;
      tmp_ff        <= tmp_in;
      mul_ff        <= mul_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign stat.clr_last = (clr_ff == AW'(NODE_COUNT - 1));
   assign stat.bad      = bad_ff;
   assign stat.is_query = is_query;
   assign stat.n_ok     = n_ok;
   assign stat.covered  = (lo_ff <= cur_ff.l) && (hi_ff >= cur_ff.r);
   assign stat.phase    = cur_ff.ph;
   assign stat.has_tag  = rd_ff.pend || (rd_ff.add != '0);
   assign stat.sp_empty = (sp_ff == '0);

   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/core/lazy_range_add_assign_sum_tree_core.sv =====
// Lazy segment tree over a 1-based array of 32-bit integers: range add, range
// assign and range sum requests, one response each, one request in flight at a
// time. Node state sits in a single memory with one read and one write port,
// and every node visit is a short serial sequence. A fully covered node is read,
// then summed or written, then popped. A partly covered node is read and split
// into a left and a right phase; an add or assign then lifts the node's sum from
// its two children, and a pending tag is first pushed down to both children. A
// single element sits about ten levels down at 1024 elements. A rejected
// request answers without visiting the tree. After reset the node memory is
// swept to zero, one entry per cycle, before the first request is taken.
module lazy_range_add_assign_sum_tree_core import lrast_pkg::*; #(
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int NODE_COUNT = DEF_NODE_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [IDX_W-1:0]  req_range_low,
   input  logic [IDX_W-1:0]  req_range_high,
   input  logic [DATA_W-1:0] req_operand_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_range_sum,
   output logic              rsp_status,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [IDX_W-1:0] active_length_ff, active_length_in;
   dp_cmd_type       cmd;
   dp_stat_type      stat;

   assign pready = 1'b1;

   always_comb begin
      active_length_in = active_length_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_ACTIVE_LENGTH)) begin
         active_length_in = pwdata[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_length_ff <= ACTIVE_LENGTH_RESET;
      end else begin
         active_length_ff <= active_length_in;
      end
   end

   assign prdata = (paddr[2] == CSR_ACTIVE_LENGTH) ? 32'(active_length_ff) : '0;

   lrast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lrast_dp #(
      .MAX_LEN    (MAX_LEN),
      .NODE_COUNT (NODE_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_operand_value (req_operand_value),
      .active_length     (active_length_ff),
      .rsp_range_sum     (rsp_range_sum),
      .rsp_status        (rsp_status)
   );

`ifndef ASSERT_OFF
   // rejected requests never carry a sum
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_range_sum == '0)
      else $error("rejected request with nonzero sum");

   // one request in flight at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a request is not taken just as reset ends, at the start of the clearing sweep
   a_no_take_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request accepted before memory clear");
`endif

endmodule

// ===== sim/lazy_tree_checker.sv =====
// request/response checker: mirrors the lazy tree and compares every response
module lazy_tree_checker import lrast_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [IDX_W-1:0]  req_range_low,
   input  logic [IDX_W-1:0]  req_range_high,
   input  logic [DATA_W-1:0] req_operand_value,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [DATA_W-1:0] rsp_range_sum,
   input  logic              rsp_status,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output int                mismatches,
   output int                awaited,
   output int                requests_seen,
   output int                queries_seen,
   output int                rejects_seen
);

   localparam int NODES     = DEF_NODE_COUNT;
   localparam int STACK_MAX = 64;

   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic              status;
   } outcome_type;

   logic [DATA_W-1:0] tree_sum [NODES];
   logic [DATA_W-1:0] tree_add [NODES];
   logic [DATA_W-1:0] tree_aval [NODES];
   logic              tree_pend [NODES];
   logic [IDX_W-1:0]  length_reg;
   outcome_type       expected_rsp [$];

   function automatic int eff_length();
      if (length_reg == 0) return 1;
      if (length_reg > DEF_MAX_LEN) return DEF_MAX_LEN;
      return int'(length_reg);
   endfunction

   function automatic logic [DATA_W-1:0] node_total(int n);
      return (n < NODES) ? tree_sum[n] : '0;
   endfunction

   function automatic void put_assign(int n, logic [DATA_W-1:0] v, int cnt);
      if (n >= NODES) return;
      tree_pend[n] = 1'b1;
      tree_aval[n] = v;
      tree_add[n]  = '0;
      tree_sum[n]  = v * DATA_W'(cnt);
   endfunction

   function automatic void put_add(int n, logic [DATA_W-1:0] v, int cnt);
      if (n >= NODES) return;
      tree_add[n] = tree_add[n] + v;
      tree_sum[n] = tree_sum[n] + v * DATA_W'(cnt);
   endfunction

   // assign goes down before add, then the parent tags are cleared
   function automatic void push_tags(int n, int lcnt, int rcnt);
      if (n >= NODES) return;
      if (tree_pend[n]) begin
         put_assign(2 * n, tree_aval[n], lcnt);
         put_assign(2 * n + 1, tree_aval[n], rcnt);
         tree_pend[n] = 1'b0;
      end
      if (tree_add[n] != 0) begin
         put_add(2 * n, tree_add[n], lcnt);
         put_add(2 * n + 1, tree_add[n], rcnt);
         tree_add[n] = '0;
      end
   endfunction

   // walks the tree with an explicit stack; returns the range sum for a query
   function automatic logic [DATA_W-1:0] tree_walk(logic [1:0] kind, int lo, int hi,
                                                   logic [DATA_W-1:0] v, int len);
      int                st_l [STACK_MAX];
      int                st_r [STACK_MAX];
      int                st_n [STACK_MAX];
      int                st_stage [STACK_MAX];
      int                sp;
      int                l;
      int                r;
      int                n;
      int                mid;
      logic [DATA_W-1:0] acc;
      acc = '0;
      sp = 1;
      st_l[0] = 1; st_r[0] = len; st_n[0] = 1; st_stage[0] = 0;
      while (sp > 0) begin
         l = st_l[sp-1]; r = st_r[sp-1]; n = st_n[sp-1];
         mid = (l + r) >> 1;
         if (st_stage[sp-1] == 0) begin
            if (n >= NODES) begin
               sp--;
            end else if (lo <= l && hi >= r) begin
               if (kind == REQ_SUM) acc = acc + tree_sum[n];
               else if (kind == REQ_ADD) put_add(n, v, r - l + 1);
               else put_assign(n, v, r - l + 1);
               sp--;
            end else begin
               push_tags(n, mid - l + 1, r - mid);
               st_stage[sp-1] = 1;
               if (lo <= mid) begin
                  st_l[sp] = l; st_r[sp] = mid; st_n[sp] = 2 * n; st_stage[sp] = 0;
                  sp++;
               end
            end
         end else if (st_stage[sp-1] == 1) begin
            st_stage[sp-1] = 2;
            if (hi > mid) begin
               st_l[sp] = mid + 1; st_r[sp] = r; st_n[sp] = 2 * n + 1; st_stage[sp] = 0;
               sp++;
            end
         end else begin
            if (kind != REQ_SUM) tree_sum[n] = node_total(2 * n) + node_total(2 * n + 1);
            sp--;
         end
      end
      return acc;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
      $display("mismatch on %s: expected %h, got %h", what, want, got);
      mismatches++;
   endtask

   assign awaited = expected_rsp.size();

   always @(posedge clock) begin
      outcome_type want;
      int          len;
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            tree_sum[i] = '0; tree_add[i] = '0; tree_aval[i] = '0; tree_pend[i] = 1'b0;
         end
         length_reg = ACTIVE_LENGTH_RESET;
         expected_rsp.delete();
         mismatches = 0; requests_seen = 0; queries_seen = 0; rejects_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_range_sum);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_range_sum !== want.sum)
                  report_mismatch("range_sum", want.sum, rsp_range_sum);
               if (rsp_status !== want.status)
                  report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            len = eff_length();
            want.sum = '0;
            want.status = (req_type == REQ_RESERVED) || (req_range_low == 0) ||
                          (req_range_low > req_range_high) || (req_range_high > len);
            if (!want.status)
               want.sum = tree_walk(req_type, int'(req_range_low), int'(req_range_high),
                                    req_operand_value, len);
            if (!want.status && req_type != REQ_SUM) want.sum = '0;
            if (want.status) rejects_seen++;
            else if (req_type == REQ_SUM) queries_seen++;
            requests_seen++;
            expected_rsp.push_back(want);
         end
         if (psel && penable && pwrite && pready && paddr == 3'(4 * CSR_ACTIVE_LENGTH))
            length_reg = pwdata[IDX_W-1:0];
      end
   end

endmodule

// ===== sim/lazy_range_add_assign_sum_tree_core_test.sv =====
// stimulus and verdict for the lazy range add/assign/sum tree core
module lazy_range_add_assign_sum_tree_core_test;
   import lrast_pkg::*;

   localparam int STALL_LIMIT  = 20000;
   localparam int SEGMENTS     = 7;
   localparam int SEGMENT_REQS = 265;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_type;
   logic [IDX_W-1:0]  req_range_low;
   logic [IDX_W-1:0]  req_range_high;
   logic [DATA_W-1:0] req_operand_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_range_sum;
   logic              rsp_status;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   int mismatches;
   int awaited;
   int requests_seen;
   int queries_seen;
   int rejects_seen;
   int tx_idle_pct;
   int rx_idle_pct;
   int quiet_cycles;
   int cur_len;

   lazy_range_add_assign_sum_tree_core dut (.*);

   lazy_tree_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no progress for %0d cycles", STALL_LIMIT);
         $display("FAIL lazy_range_add_assign_sum_tree_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_req(logic [1:0] kind, int lo, int hi, logic [DATA_W-1:0] v);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_range_low     <= IDX_W'(lo);
      req_range_high    <= IDX_W'(hi);
      req_operand_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_length(logic [IDX_W-1:0] val);
      @(negedge clock);
      req_valid <= 1'b0;
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 3'(4 * CSR_ACTIVE_LENGTH); pwdata <= 32'(val);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      cur_len = (val == 0) ? 1 : ((val > DEF_MAX_LEN) ? DEF_MAX_LEN : int'(val));
   endtask

   // pause the sender until every response is back, then let the core settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic random_req();
      int                pick;
      int                w;
      int                lo;
      logic [1:0]        kind;
      logic [DATA_W-1:0] v;
      pick = $urandom_range(0, 99);
      v = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 15)) - 8 : $urandom;
      if (pick >= 95) begin
         case ($urandom_range(0, 4))
            0: send_req(REQ_RESERVED, $urandom_range(0, 2047), $urandom_range(0, 2047), v);
            1: send_req(2'($urandom_range(0, 2)), 0, $urandom_range(0, cur_len), v);
            2: begin
               lo = $urandom_range(2, 2047);
               send_req(2'($urandom_range(0, 2)), lo, $urandom_range(1, lo - 1), v);
            end
            3: send_req(2'($urandom_range(0, 2)), $urandom_range(1, cur_len),
                        $urandom_range(cur_len + 1, 2047), v);
            default: send_req(2'($urandom), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), v);
         endcase
      end else begin
         kind = (pick < 30) ? REQ_ADD : ((pick < 58) ? REQ_ASSIGN : REQ_SUM);
         pick = $urandom_range(0, 99);
         if (pick < 70) w = $urandom_range(0, (cur_len < 16) ? cur_len - 1 : 15);
         else if (pick < 90) w = $urandom_range(0, cur_len - 1);
         else w = cur_len - 1;
         lo = $urandom_range(1, cur_len - w);
         send_req(kind, lo, lo + w, v);
      end
   endtask

   initial begin
      logic [IDX_W-1:0] lengths [SEGMENTS];
      lengths = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd1000, 11'd37, 11'd5};
      reset = 1'b1;
      req_valid = 1'b0; req_type = REQ_ADD; req_range_low = '0; req_range_high = '0;
      req_operand_value = '0; rsp_ready = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      tx_idle_pct = 18; rx_idle_pct = 51; quiet_cycles = 0; cur_len = DEF_MAX_LEN;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int s = 0; s < SEGMENTS; s++) begin
         if (s == 3) begin
            tx_idle_pct = 51; rx_idle_pct = 18;
         end else if (s == 5) begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         if (s > 0) drain();
         write_length(lengths[s]);
         if (s == 0) begin
            // extremes of the range and value fields, and each rejection
            send_req(REQ_SUM, 1, 1024, 32'h0);
            send_req(REQ_ASSIGN, 1, 1024, 32'h7fffffff);
            send_req(REQ_ADD, 1, 1, 32'hffffffff);
            send_req(REQ_ADD, 1024, 1024, 32'h80000000);
            send_req(REQ_SUM, 1, 1024, 32'h0);
            send_req(REQ_SUM, 512, 513, 32'hffffffff);
            send_req(REQ_ASSIGN, 5, 5, 32'h0);
            send_req(REQ_ADD, 0, 4, 32'h1);
            send_req(REQ_ASSIGN, 9, 8, 32'h1);
            send_req(REQ_SUM, 1, 1025, 32'h0);
            send_req(REQ_SUM, 2047, 2047, 32'h0);
            send_req(REQ_RESERVED, 1, 2, 32'hffffffff);
            send_req(REQ_SUM, 1, 1024, 32'h0);
            send_req(REQ_ASSIGN, 1, 1024, 32'hffffffff);
            send_req(REQ_ADD, 3, 700, 32'h1);
            send_req(REQ_SUM, 1, 1024, 32'h0);
            send_req(REQ_SUM, 700, 701, 32'h0);
            send_req(REQ_SUM, 2, 3, 32'h0);
         end
         for (int i = 0; i < SEGMENT_REQS; i++) random_req();
      end
      drain();

      $display("ran %0d requests (%0d sums, %0d rejected) over %0d lengths", requests_seen,
               queries_seen, rejects_seen, SEGMENTS);
      $display("pacing: sender-light, receiver-light and back-to-back stretches");
      if (mismatches == 0) begin
         $display("PASS lazy_range_add_assign_sum_tree_core");
      end else begin
         $display("FAIL lazy_range_add_assign_sum_tree_core");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/lrast_pkg.sv
rtl/core/lrast_ctrl.sv
rtl/core/lrast_dp.sv
rtl/core/lazy_range_add_assign_sum_tree_core.sv
sim/lazy_tree_checker.sv
sim/lazy_range_add_assign_sum_tree_core_test.sv
